[hdl/lruetf_pkg.sv]
// Shared types and constants for the LRU evict-to-free-space block.
// No dependencies; used by lruetf_table, lruetf_ctrl and lru_evict_to_free_space_core.
`timescale 1ns / 1ps
`default_nettype none

package lruetf_pkg;

    // Defaults for the top-level parameters
    localparam int ENTRIES_DEF   = 32;
    localparam int TIME_BITS_DEF = 32;
    localparam int SIZE_BITS_DEF = 32;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int SLOT_W   = 5;
    localparam int FIELD_W  = 32;
    localparam int COUNT_W  = 6;
    localparam int SPACE_W  = 37;
    localparam int STATUS_W = 2;

    // Results per input word are capped
    localparam int MAX_OUT = 32;
    localparam int K_W     = $clog2(MAX_OUT + 1);

    // Operation codes
    localparam logic [OP_W-1:0] OP_WRITE      = 2'd0;
    localparam logic [OP_W-1:0] OP_EVICT_ONE  = 2'd1;
    localparam logic [OP_W-1:0] OP_EVICT_FREE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_EVICTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [SLOT_W-1:0]  slot;
        logic               entry_valid;
        logic               entry_evictable;
        logic [FIELD_W-1:0] entry_time;
        logic [FIELD_W-1:0] entry_size;
        logic [SPACE_W-1:0] amount_to_free;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   evicted_slot;
        logic [FIELD_W-1:0]  evicted_size;
        logic [COUNT_W-1:0]  files_held;
        logic [SPACE_W-1:0]  space_held;
        logic                last;
    } out_word_t;

    // Table control from the sequencer
    typedef struct packed {
        logic wr_en;     // write entry data and its valid bit
        logic wr_valid;  // valid bit value on a write
        logic clr_en;    // drop the valid bit of the evicted slot
    } tbl_ctl_t;

endpackage

`default_nettype wire

[hdl/lruetf_table.sv]
// Entry table: synchronous memory for evictable flag, time and size, plus
// per-slot valid flip-flops. Depends on lruetf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lruetf_table #(
    parameter int ENTRIES   = lruetf_pkg::ENTRIES_DEF,
    parameter int TIME_BITS = lruetf_pkg::TIME_BITS_DEF,
    parameter int SIZE_BITS = lruetf_pkg::SIZE_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  lruetf_pkg::tbl_ctl_t                    ctl,
    input  logic [$clog2(ENTRIES)-1:0]              wr_addr,
    input  logic [$clog2(ENTRIES)-1:0]              clr_addr,
    input  logic                                    wr_evict,
    input  logic [((TIME_BITS < 32) ? TIME_BITS : 32)-1:0] wr_time,
    input  logic [((SIZE_BITS < 32) ? SIZE_BITS : 32)-1:0] wr_size,
    input  logic [$clog2(ENTRIES)-1:0]              rd_addr,
    output logic                                    rd_valid,
    output logic                                    rd_evict,
    output logic [((TIME_BITS < 32) ? TIME_BITS : 32)-1:0] rd_time,
    output logic [((SIZE_BITS < 32) ? SIZE_BITS : 32)-1:0] rd_size
);

    localparam int TIME_W = (TIME_BITS < 32) ? TIME_BITS : 32;
    localparam int SIZE_W = (SIZE_BITS < 32) ? SIZE_BITS : 32;
    localparam int WORD_W = 1 + TIME_W + SIZE_W;

    logic [WORD_W-1:0] mem [ENTRIES];
    logic [WORD_W-1:0] rd_word_reg;
    logic [ENTRIES-1:0] valid_bits_reg;
    logic               rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= {wr_evict, wr_time, wr_size};
        end
    end

    always_ff @(posedge aclk) begin
        rd_word_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_bits_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end else begin
            if (ctl.wr_en) begin
                valid_bits_reg[wr_addr] <= ctl.wr_valid;
            end else if (ctl.clr_en) begin
                valid_bits_reg[clr_addr] <= 1'b0;
            end
            rd_valid_reg <= valid_bits_reg[rd_addr];
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_evict = rd_word_reg[WORD_W-1];
    assign rd_time  = rd_word_reg[SIZE_W +: TIME_W];
    assign rd_size  = rd_word_reg[SIZE_W-1:0];

`ifndef SYNTH
    a_clr_hits_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.clr_en |-> valid_bits_reg[clr_addr])
        else $error("eviction clears a slot that is not valid");

    a_no_wr_clr_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl.wr_en && ctl.clr_en))
        else $error("write and eviction clear in the same cycle");
`endif

endmodule

`default_nettype wire

[hdl/lruetf_ctrl.sv]
// Sequencer: decodes input words, runs the table scan for the oldest
// evictable slot, keeps the totals and drives the result register.
// Depends on lruetf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lruetf_ctrl #(
    parameter int ENTRIES   = lruetf_pkg::ENTRIES_DEF,
    parameter int TIME_BITS = lruetf_pkg::TIME_BITS_DEF,
    parameter int SIZE_BITS = lruetf_pkg::SIZE_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  lruetf_pkg::in_word_t                    s_data,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output lruetf_pkg::out_word_t                   m_data,
    output lruetf_pkg::tbl_ctl_t                    ctl,
    output logic [$clog2(ENTRIES)-1:0]              wr_addr,
    output logic [$clog2(ENTRIES)-1:0]              clr_addr,
    output logic                                    wr_evict,
    output logic [((TIME_BITS < 32) ? TIME_BITS : 32)-1:0] wr_time,
    output logic [((SIZE_BITS < 32) ? SIZE_BITS : 32)-1:0] wr_size,
    output logic [$clog2(ENTRIES)-1:0]              rd_addr,
    input  logic                                    rd_valid,
    input  logic                                    rd_evict,
    input  logic [((TIME_BITS < 32) ? TIME_BITS : 32)-1:0] rd_time,
    input  logic [((SIZE_BITS < 32) ? SIZE_BITS : 32)-1:0] rd_size
);

    localparam int TIME_W  = (TIME_BITS < 32) ? TIME_BITS : 32;
    localparam int SIZE_W  = (SIZE_BITS < 32) ? SIZE_BITS : 32;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int SPACE_W = lruetf_pkg::SPACE_W;
    localparam int COUNT_W = lruetf_pkg::COUNT_W;
    localparam int FREED_W = SPACE_W + 1;
    localparam int K_W     = lruetf_pkg::K_W;

    typedef enum logic [2:0] {
        IDLE,
        WR_WAIT,
        WR_ADD,
        CHECK,
        SCAN,
        EVICT,
        EMIT
    } state_t;

    state_t state_reg;

    // latched input word
    logic [lruetf_pkg::OP_W-1:0] op_reg;
    logic [IDX_W-1:0]            slot_reg;
    logic                        valid_in_reg;
    logic                        evict_in_reg;
    logic [TIME_W-1:0]           time_reg;
    logic [SIZE_W-1:0]           size_reg;
    logic [SPACE_W-1:0]          amount_reg;

    // totals
    logic [COUNT_W-1:0] count_reg;
    logic [SPACE_W-1:0] space_reg;

    // scan
    logic [CNT_W-1:0]  issue_cnt_reg;
    logic              cmp_vld_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic              best_found_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [TIME_W-1:0] best_time_reg;
    logic [SIZE_W-1:0] best_size_reg;

    logic [FREED_W-1:0] freed_reg;
    logic [K_W-1:0]     k_reg;
    logic [lruetf_pkg::STATUS_W-1:0] res_status_reg;

    logic                  m_valid_reg;
    lruetf_pkg::out_word_t m_data_reg;

    logic               out_free;
    logic               res_load;
    logic               cand;
    logic               scan_issue;
    logic [COUNT_W-1:0] count_dec;
    logic [SPACE_W-1:0] space_evict;
    logic [FREED_W-1:0] freed_next;
    logic               evict_last;

    assign out_free   = !m_valid_reg || m_ready;
    // a result word is loaded this cycle
    assign res_load   = out_free && ((state_reg == EMIT) ||
                                     ((state_reg == EVICT) && best_found_reg));
    assign scan_issue = (state_reg == SCAN) && (issue_cnt_reg < CNT_W'(ENTRIES));
    assign cand       = cmp_vld_reg && rd_valid && rd_evict &&
                        (!best_found_reg || (rd_time < best_time_reg));

    assign count_dec   = count_reg - 1'b1;
    assign space_evict = space_reg - SPACE_W'(best_size_reg);
    assign freed_next  = freed_reg + FREED_W'(best_size_reg);
    assign evict_last  = (op_reg != lruetf_pkg::OP_EVICT_FREE) ||
                         (freed_next >= FREED_W'(amount_reg)) ||
                         (k_reg + 1'b1 == K_W'(lruetf_pkg::MAX_OUT));

    assign s_ready = (state_reg == IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        if (state_reg == IDLE) begin
            rd_addr = IDX_W'(s_data.slot);
        end else begin
            rd_addr = issue_cnt_reg[IDX_W-1:0];
        end
    end

    assign ctl.wr_en    = (state_reg == WR_WAIT);
    assign ctl.wr_valid = valid_in_reg;
    assign ctl.clr_en   = (state_reg == EVICT) && best_found_reg && out_free;
    assign wr_addr      = slot_reg;
    assign clr_addr     = best_idx_reg;
    assign wr_evict     = evict_in_reg;
    assign wr_time      = time_reg;
    assign wr_size      = size_reg;

    // read data for the scan arrives in the cycle after the address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_vld_reg <= 1'b0;
        end else begin
            cmp_vld_reg <= scan_issue;
        end
        cmp_idx_reg <= issue_cnt_reg[IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= IDLE;
            count_reg      <= '0;
            space_reg      <= '0;
            issue_cnt_reg  <= '0;
            best_found_reg <= 1'b0;
            freed_reg      <= '0;
            k_reg          <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_ready && !res_load) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE: begin
                    issue_cnt_reg  <= '0;
                    best_found_reg <= 1'b0;
                    freed_reg      <= '0;
                    k_reg          <= '0;
                    if (s_valid) begin
                        op_reg       <= s_data.operation;
                        slot_reg     <= IDX_W'(s_data.slot);
                        valid_in_reg <= s_data.entry_valid;
                        evict_in_reg <= s_data.entry_evictable;
                        time_reg     <= s_data.entry_time[TIME_W-1:0];
                        size_reg     <= s_data.entry_size[SIZE_W-1:0];
                        amount_reg   <= s_data.amount_to_free;
                        res_status_reg <= lruetf_pkg::ST_DONE;
                        case (s_data.operation)
                            lruetf_pkg::OP_WRITE: begin
                                if (32'(s_data.slot) < ENTRIES) begin
                                    state_reg <= WR_WAIT;
                                end else begin
                                    state_reg <= EMIT;
                                end
                            end
                            lruetf_pkg::OP_EVICT_ONE:  state_reg <= SCAN;
                            lruetf_pkg::OP_EVICT_FREE: state_reg <= CHECK;
                            default:                   state_reg <= EMIT;
                        endcase
                    end
                end
                WR_WAIT: begin
                    // old slot contents are on the read port now
                    if (rd_valid) begin
                        count_reg <= count_dec;
                        space_reg <= space_reg - SPACE_W'(rd_size);
                    end
                    state_reg <= WR_ADD;
                end
                WR_ADD: begin
                    if (valid_in_reg) begin
                        count_reg <= count_reg + 1'b1;
                        space_reg <= space_reg + SPACE_W'(size_reg);
                    end
                    state_reg <= EMIT;
                end
                CHECK: begin
                    if (amount_reg > space_reg) begin
                        res_status_reg <= lruetf_pkg::ST_TOO_BIG;
                        state_reg      <= EMIT;
                    end else if (amount_reg == '0) begin
                        state_reg <= EMIT;
                    end else begin
                        state_reg <= SCAN;
                    end
                end
                SCAN: begin
                    if (scan_issue) begin
                        issue_cnt_reg <= issue_cnt_reg + 1'b1;
                    end
                    if (cand) begin
                        best_found_reg <= 1'b1;
                        best_idx_reg   <= cmp_idx_reg;
                        best_time_reg  <= rd_time;
                        best_size_reg  <= rd_size;
                    end
                    if (cmp_vld_reg && (cmp_idx_reg == IDX_W'(ENTRIES - 1))) begin
                        state_reg <= EVICT;
                    end
                end
                EVICT: begin
                    issue_cnt_reg <= '0;
                    if (!best_found_reg) begin
                        res_status_reg <= lruetf_pkg::ST_NONE;
                        state_reg      <= EMIT;
                    end else if (out_free) begin
                        best_found_reg <= 1'b0;
                        count_reg      <= count_dec;
                        space_reg      <= space_evict;
                        freed_reg      <= freed_next;
                        k_reg          <= k_reg + 1'b1;
                        m_valid_reg    <= 1'b1;
                        m_data_reg.status       <= lruetf_pkg::ST_EVICTED;
                        m_data_reg.evicted_slot <= lruetf_pkg::SLOT_W'(best_idx_reg);
                        m_data_reg.evicted_size <= lruetf_pkg::FIELD_W'(best_size_reg);
                        m_data_reg.files_held   <= count_dec;
                        m_data_reg.space_held   <= space_evict;
                        m_data_reg.last         <= evict_last;
                        state_reg <= evict_last ? IDLE : SCAN;
                    end
                end
                EMIT: begin
                    if (out_free) begin
                        m_valid_reg             <= 1'b1;
                        m_data_reg.status       <= res_status_reg;
                        m_data_reg.evicted_slot <= '0;
                        m_data_reg.evicted_size <= '0;
                        m_data_reg.files_held   <= count_reg;
                        m_data_reg.space_held   <= space_reg;
                        m_data_reg.last         <= 1'b1;
                        state_reg               <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= ENTRIES)
        else $error("entry count above table depth");

    a_freed_below_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SCAN && op_reg == lruetf_pkg::OP_EVICT_FREE)
            |-> (freed_reg < FREED_W'(amount_reg)))
        else $error("scan continues after request was met");

    a_evict_decrements: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.clr_en |=> (count_reg == COUNT_W'($past(count_reg) - 1'b1)))
        else $error("eviction did not decrement entry count");
`endif

endmodule

`default_nettype wire

[hdl/lru_evict_to_free_space_core.sv]
// Top level of the LRU evict-to-free-space block: table memory and sequencer.
// Depends on lruetf_pkg, lruetf_table and lruetf_ctrl.
`timescale 1ns / 1ps
`default_nettype none

// LRU table of ENTRIES slots with valid/ready words in and out. One input
// word is worked at a time; s_ready is high only while the sequencer is idle,
// and a finished result may still sit in the output register while the next
// word is taken. A write reads the old slot, then writes the table and takes
// the old size off, adds the new size and loads the result. Each eviction
// scans the table through the single memory read port, one slot per cycle,
// and waits for the result side before the slot is taken out of the table.
// Ties on time go to the lowest slot. Reset clears the valid flags at once;
// no clearing pass is needed.
module lru_evict_to_free_space_core #(
    parameter int ENTRIES   = lruetf_pkg::ENTRIES_DEF,
    parameter int TIME_BITS = lruetf_pkg::TIME_BITS_DEF,
    parameter int SIZE_BITS = lruetf_pkg::SIZE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lruetf_pkg::in_word_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lruetf_pkg::out_word_t m_data
);

    localparam int TIME_W = (TIME_BITS < 32) ? TIME_BITS : 32;
    localparam int SIZE_W = (SIZE_BITS < 32) ? SIZE_BITS : 32;
    localparam int IDX_W  = $clog2(ENTRIES);

    lruetf_pkg::tbl_ctl_t ctl;
    logic [IDX_W-1:0]     wr_addr;
    logic [IDX_W-1:0]     clr_addr;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_evict;
    logic [TIME_W-1:0]    wr_time;
    logic [SIZE_W-1:0]    wr_size;
    logic                 rd_valid;
    logic                 rd_evict;
    logic [TIME_W-1:0]    rd_time;
    logic [SIZE_W-1:0]    rd_size;

    lruetf_ctrl #(
        .ENTRIES   (ENTRIES),
        .TIME_BITS (TIME_BITS),
        .SIZE_BITS (SIZE_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .ctl      (ctl),
        .wr_addr  (wr_addr),
        .clr_addr (clr_addr),
        .wr_evict (wr_evict),
        .wr_time  (wr_time),
        .wr_size  (wr_size),
        .rd_addr  (rd_addr),
        .rd_valid (rd_valid),
        .rd_evict (rd_evict),
        .rd_time  (rd_time),
        .rd_size  (rd_size)
    );

    lruetf_table #(
        .ENTRIES   (ENTRIES),
        .TIME_BITS (TIME_BITS),
        .SIZE_BITS (SIZE_BITS)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .wr_addr  (wr_addr),
        .clr_addr (clr_addr),
        .wr_evict (wr_evict),
        .wr_time  (wr_time),
        .wr_size  (wr_size),
        .rd_addr  (rd_addr),
        .rd_valid (rd_valid),
        .rd_evict (rd_evict),
        .rd_time  (rd_time),
        .rd_size  (rd_size)
    );

endmodule

`default_nettype wire

[verif/lru_evict_to_free_space_core_test.sv]
// Self-checking bench for lru_evict_to_free_space_core: a directed table of words, then random
// traffic, each result word checked against a typed result or an in-bench LRU table predictor.
// Depends on lruetf_pkg and lru_evict_to_free_space_core.
`timescale 1ns / 1ps

module lru_evict_to_free_space_core_test;

    localparam int OP_W     = lruetf_pkg::OP_W;
    localparam int SLOT_W   = lruetf_pkg::SLOT_W;
    localparam int FIELD_W  = lruetf_pkg::FIELD_W;
    localparam int COUNT_W  = lruetf_pkg::COUNT_W;
    localparam int SPACE_W  = lruetf_pkg::SPACE_W;
    localparam int STATUS_W = lruetf_pkg::STATUS_W;

    localparam int NSLOT = lruetf_pkg::ENTRIES_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 128;
    localparam int HOLD_AFTER_WORDS = 90;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 4 * (lruetf_pkg::ENTRIES_DEF + 3);

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    lruetf_pkg::in_word_t  s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    lruetf_pkg::out_word_t m_data;

    lru_evict_to_free_space_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // LRU table predictor state
    logic               tbl_valid     [NSLOT];
    logic               tbl_evictable [NSLOT];
    logic [FIELD_W-1:0] tbl_time      [NSLOT];
    logic [FIELD_W-1:0] tbl_size      [NSLOT];
    logic [COUNT_W-1:0] held_count;
    logic [SPACE_W-1:0] held_space;

    lruetf_pkg::out_word_t step_results[$];
    lruetf_pkg::out_word_t expected_q[$];

    typedef struct {
        lruetf_pkg::in_word_t  word;
        bit                    typed;
        lruetf_pkg::out_word_t result;
    } step_t;
    step_t plan[$];

    int  mismatches = 0;
    int  results_checked = 0;
    int  evictions_seen = 0;
    int  words_sent = 0;
    bit  burst = 1'b0;
    bit  hold_results = 1'b0;

    function automatic lruetf_pkg::out_word_t make_result(logic [STATUS_W-1:0] st,
                                                          int slot_idx,
                                                          logic [FIELD_W-1:0] sz,
                                                          logic lst);
        lruetf_pkg::out_word_t r;
        r.status       = st;
        r.evicted_slot = slot_idx[SLOT_W-1:0];
        r.evicted_size = sz;
        r.files_held   = held_count;
        r.space_held   = held_space;
        r.last         = lst;
        return r;
    endfunction

    // Oldest valid, evictable slot; lowest index wins a tie. -1 if none.
    function automatic int take_oldest();
        int best;
        int i;
        best = -1;
        for (i = 0; i < NSLOT; i++) begin
            if (tbl_valid[i] && tbl_evictable[i]) begin
                if (best < 0) best = i;
                else if (tbl_time[i] < tbl_time[best]) best = i;
            end
        end
        if (best >= 0) begin
            tbl_valid[best] = 1'b0;
            held_count = held_count - 1'b1;
            held_space = held_space - tbl_size[best];
        end
        return best;
    endfunction

    task automatic predict_word(input lruetf_pkg::in_word_t w);
        int                    victim;
        logic [63:0]           freed;
        lruetf_pkg::out_word_t r;
        step_results.delete();
        case (w.operation)
            lruetf_pkg::OP_WRITE: begin
                if (tbl_valid[w.slot]) begin
                    held_count = held_count - 1'b1;
                    held_space = held_space - tbl_size[w.slot];
                end
                tbl_valid[w.slot]     = w.entry_valid;
                tbl_evictable[w.slot] = w.entry_evictable;
                tbl_time[w.slot]      = w.entry_time;
                tbl_size[w.slot]      = w.entry_size;
                if (w.entry_valid) begin
                    held_count = held_count + 1'b1;
                    held_space = held_space + w.entry_size;
                end
                step_results.push_back(make_result(lruetf_pkg::ST_DONE, 0, '0, 1'b1));
            end
            lruetf_pkg::OP_EVICT_ONE: begin
                victim = take_oldest();
                if (victim < 0) begin
                    step_results.push_back(make_result(lruetf_pkg::ST_NONE, 0, '0, 1'b1));
                end else begin
                    step_results.push_back(make_result(lruetf_pkg::ST_EVICTED, victim,
                                                       tbl_size[victim], 1'b1));
                end
            end
            lruetf_pkg::OP_EVICT_FREE: begin
                if (w.amount_to_free > held_space) begin
                    step_results.push_back(make_result(lruetf_pkg::ST_TOO_BIG, 0, '0, 1'b1));
                end else if (w.amount_to_free == '0) begin
                    step_results.push_back(make_result(lruetf_pkg::ST_DONE, 0, '0, 1'b1));
                end else begin
                    freed = '0;
                    victim = 0;
                    while (victim >= 0 && freed < 64'(w.amount_to_free)
                           && step_results.size() < lruetf_pkg::MAX_OUT) begin
                        victim = take_oldest();
                        if (victim < 0) begin
                            step_results.push_back(
                                make_result(lruetf_pkg::ST_NONE, 0, '0, 1'b1));
                        end else begin
                            freed = freed + tbl_size[victim];
                            step_results.push_back(make_result(lruetf_pkg::ST_EVICTED,
                                                               victim, tbl_size[victim],
                                                               1'b0));
                        end
                    end
                    r = step_results.pop_back();
                    r.last = 1'b1;
                    step_results.push_back(r);
                end
            end
            default: step_results.push_back(make_result(lruetf_pkg::ST_DONE, 0, '0, 1'b1));
        endcase
    endtask

    task automatic add_step(logic [OP_W-1:0] op, int slot_idx, logic v, logic e,
                            logic [FIELD_W-1:0] t, logic [FIELD_W-1:0] sz,
                            logic [SPACE_W-1:0] amt, bit typed = 1'b0,
                            logic [STATUS_W-1:0] st = lruetf_pkg::ST_DONE,
                            logic [COUNT_W-1:0] files = '0,
                            logic [SPACE_W-1:0] space = '0);
        step_t s;
        s.word.operation       = op;
        s.word.slot            = slot_idx[SLOT_W-1:0];
        s.word.entry_valid     = v;
        s.word.entry_evictable = e;
        s.word.entry_time      = t;
        s.word.entry_size      = sz;
        s.word.amount_to_free  = amt;
        s.typed                = typed;
        s.result.status        = st;
        s.result.evicted_slot  = '0;
        s.result.evicted_size  = '0;
        s.result.files_held    = files;
        s.result.space_held    = space;
        s.result.last          = 1'b1;
        plan.push_back(s);
    endtask

    function automatic int draw_gap();
        return burst ? 0 : $urandom_range(0, 6);
    endfunction

    // Mostly well-formed traffic sized against what the table holds right now.
    function automatic lruetf_pkg::in_word_t random_word();
        lruetf_pkg::in_word_t w;
        logic [127:0]         raw;
        logic [63:0]          span;
        int                   pick;
        raw  = {$urandom, $urandom, $urandom, $urandom};
        w    = raw[$bits(lruetf_pkg::in_word_t)-1:0];
        span = 64'(held_space);
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            w.operation       = lruetf_pkg::OP_WRITE;
            w.entry_valid     = ($urandom_range(0, 9) < 8);
            w.entry_evictable = ($urandom_range(0, 9) < 7);
            // narrow time range forces ties
            if ($urandom_range(0, 1)) w.entry_time = $urandom_range(0, 31);
            if ($urandom_range(0, 9) < 7) w.entry_size = $urandom_range(0, 4095);
        end else if (pick < 65) begin
            w.operation = lruetf_pkg::OP_EVICT_ONE;
        end else if (pick < 93) begin
            w.operation = lruetf_pkg::OP_EVICT_FREE;
            pick = $urandom_range(0, 9);
            if (pick < 5) w.amount_to_free = (span == 0) ? '0 :
                                             SPACE_W'(64'd1 + {$urandom, $urandom} % span);
            else if (pick < 6) w.amount_to_free = SPACE_W'(span);
            else if (pick < 7) w.amount_to_free = SPACE_W'(span + 64'd1);
            else if (pick < 8) w.amount_to_free = '0;
        end else begin
            w.operation = OP_UNUSED;
        end
        return w;
    endfunction

    task automatic send_word(input lruetf_pkg::in_word_t w, input bit typed,
                             input lruetf_pkg::out_word_t typed_res);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        predict_word(w);
        if (typed) expected_q.push_back(typed_res);
        else foreach (step_results[i]) expected_q.push_back(step_results[i]);
        words_sent++;
    endtask

    function automatic string show_result(lruetf_pkg::out_word_t r);
        return $sformatf("status=%0d slot=%0d size=%0h files=%0d space=%0h last=%0b",
                         r.status, r.evicted_slot, r.evicted_size, r.files_held,
                         r.space_held, r.last);
    endfunction

    task automatic check_result(input lruetf_pkg::out_word_t got);
        lruetf_pkg::out_word_t want;
        results_checked++;
        if (got.status == lruetf_pkg::ST_EVICTED) evictions_seen++;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result word: %s", show_result(got));
            return;
        end
        want = expected_q.pop_front();
        if (got.status !== want.status || got.evicted_slot !== want.evicted_slot
            || got.evicted_size !== want.evicted_size || got.files_held !== want.files_held
            || got.space_held !== want.space_held || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Result word %0d mismatch", results_checked);
                $display("  expected %s", show_result(want));
                $display("  actual   %s", show_result(got));
            end
        end
    endtask

    // Result side: random stalls that land while a word is waiting
    initial begin
        int gap;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = draw_gap();
            if (gap > 0 || hold_results) begin
                m_ready <= 1'b0;
                do @(posedge aclk); while (!m_valid);
                while (hold_results) @(posedge aclk);
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            check_result(m_data);
        end
    end

    // Long result-side hold-off so the core backs up and drops s_ready
    initial begin
        wait (words_sent >= HOLD_AFTER_WORDS);
        @(negedge aclk);
        hold_results = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        @(negedge aclk);
        hold_results = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int i;
        held_count = '0;
        held_space = '0;
        for (i = 0; i < NSLOT; i++) begin
            tbl_valid[i]     = 1'b0;
            tbl_evictable[i] = 1'b0;
            tbl_time[i]      = '0;
            tbl_size[i]      = '0;
        end

        // empty table corners, then extremes and the eviction special cases
        add_step(lruetf_pkg::OP_EVICT_ONE,  0, 0, 0, 0, 0, 0, 1'b1, lruetf_pkg::ST_NONE, 0, 0);
        add_step(lruetf_pkg::OP_EVICT_FREE, 0, 0, 0, 0, 0, 1, 1'b1, lruetf_pkg::ST_TOO_BIG,
                 0, 0);
        add_step(lruetf_pkg::OP_EVICT_FREE, 0, 0, 0, 0, 0, 0, 1'b1, lruetf_pkg::ST_DONE, 0, 0);
        add_step(OP_UNUSED, 31, 1, 1, '1, '1, '1, 1'b1, lruetf_pkg::ST_DONE, 0, 0);
        add_step(lruetf_pkg::OP_WRITE,  0, 1, 1, '1, '1, 0, 1'b1, lruetf_pkg::ST_DONE, 1,
                 37'hFFFF_FFFF);
        add_step(lruetf_pkg::OP_WRITE, 31, 1, 1, 0, 0, 0, 1'b1, lruetf_pkg::ST_DONE, 2,
                 37'hFFFF_FFFF);
        add_step(lruetf_pkg::OP_WRITE,  5, 1, 0, 5, 100, 0);     // pinned entry
        add_step(lruetf_pkg::OP_WRITE,  7, 1, 1, 5, 300, 0);
        add_step(lruetf_pkg::OP_WRITE,  3, 1, 1, 5, 200, 0);
        add_step(lruetf_pkg::OP_EVICT_ONE, 0, 0, 0, 0, 0, 0);    // oldest: slot 31
        add_step(lruetf_pkg::OP_EVICT_ONE, 0, 0, 0, 0, 0, 0);    // tie 3 vs 7, low slot wins
        add_step(lruetf_pkg::OP_WRITE,  0, 1, 1, 1, 50, 0);      // overwrite a held slot
        add_step(lruetf_pkg::OP_WRITE,  9, 0, 0, 0, 0, 0);       // clear an empty slot
        add_step(lruetf_pkg::OP_WRITE,  5, 0, 0, 0, 0, 0);
        add_step(lruetf_pkg::OP_WRITE, 10, 1, 0, 0, 1000, 0);
        add_step(lruetf_pkg::OP_EVICT_FREE, 0, 0, 0, 0, 0, 37'h1F_FFFF_FFFF);
        add_step(lruetf_pkg::OP_EVICT_FREE, 0, 0, 0, 0, 0, 310); // two evictions
        add_step(lruetf_pkg::OP_WRITE, 12, 1, 1, 2, 10, 0);
        add_step(lruetf_pkg::OP_EVICT_FREE, 0, 0, 0, 0, 0, 500); // runs dry after one
        add_step(lruetf_pkg::OP_EVICT_FREE, 0, 0, 0, 0, 0, 1000); // nothing evictable at all
        add_step(lruetf_pkg::OP_WRITE, 10, 1, 1, '1, 1000, 0);
        add_step(lruetf_pkg::OP_EVICT_FREE, 0, 0, 0, 0, 0, 1000); // request equals held space

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) send_word(plan[i].word, plan[i].typed, plan[i].result);
        for (i = 0; i < RANDOM_WORDS; i++) begin
            burst = (i >= 30 && i < 60) || (i >= 100 && i < 125);
            send_word(random_word(), 1'b0, '0);
        end
        s_valid <= 1'b0;
        burst = 1'b0;

        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d words (%0d from the directed table), checked %0d result words,",
                 words_sent, plan.size(), results_checked);
        $display("%0d of them evictions; %0d mismatches.", evictions_seen, mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/lruetf_pkg.sv
hdl/lruetf_table.sv
hdl/lruetf_ctrl.sv
hdl/lru_evict_to_free_space_core.sv
verif/lru_evict_to_free_space_core_test.sv
